[rtl/tsd_pkg.sv]
package tsd_pkg;

    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MIN_W      = 12;
    localparam int MAX_W      = 13;
    localparam int WIN_W      = 16;
    localparam int MAG_W      = 13;
    localparam int NUM_W      = 20;
    localparam int DEN_W      = 13;
    localparam int Q_W        = 7;
    localparam int SPEED_W    = 8;
    localparam int SHIFT_W    = 17;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_DOWN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UP   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLING_MIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLING_MAX_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLING_MIN_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLING_MAX_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW = 3'd4;

    // register reset values
    localparam logic [MIN_W-1:0] FLING_MIN_RST    = 12'd20;
    localparam logic [MAX_W-1:0] FLING_MAX_RST    = 13'd200;
    localparam logic [WIN_W-1:0] CLICK_WINDOW_RST = 16'd300;

    localparam int FLING_GAP_MS = 60;
    localparam int SPEED_FULL   = 100;
    localparam int DRAG_START   = 24;
    localparam int Y_OFFSET     = 15;
    localparam int REMAP_LOW    = -10;
    localparam int REMAP_MID    = -5;
    localparam int REMAP_HIGH   = 1;
    localparam int REMAP_LOW_V  = 1;
    localparam int REMAP_MID_V  = 2;
    localparam int REMAP_HIGH_V = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_EXCESS,
        ST_LAUNCH,
        ST_WAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           busy;
        logic           done;
        logic [Q_W-1:0] quo;
    } div_rsp_t;

endpackage

[rtl/tsd_div.sv]
module tsd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tsd_pkg::div_req_t req,
    output tsd_pkg::div_rsp_t rsp
);
    import tsd_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic             ge;

    // restoring divide, one quotient bit per cycle; quotient is known to fit Q_W bits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        ge        = rem_reg >= dsh_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.num;
            dsh_next  = NUM_W'(req.den) << (Q_W - 1);
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[Q_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == CNT_W'(Q_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

endmodule

[rtl/touch_swipe_detector_top.sv]
// Touch swipe detector. Takes one touch event (down, move, up) per transfer and returns one
// status result per event: a fling speed (-100..100) on a quick up, a drag shift once travel
// reaches 24 counts (any nonzero shift once moving), plus the moving and click flags. The
// result is registered after the delta, excess and finish states; when a fling speed is
// scaled, a launch state and a wait on the 7-step restoring divider come before finish.
// The block returns to idle as it presents the result. The input is
// stalled while an event is in work; a finished result waits in the finish state until the
// output register is free. The user must write registers only while idle; the block itself
// does not enforce it. Event kind 3 is ignored and reports the current flags.
module touch_swipe_detector_top #(
    parameter int COORD_BITS = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tsd_pkg::KIND_W-1:0]       event_kind,
    input  logic signed [COORD_BITS-1:0]     touch_x,
    input  logic signed [COORD_BITS-1:0]     touch_y,
    input  logic [STAMP_BITS-1:0]            stamp_ms,
    input  logic                             axis_is_x,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             gesture_valid,
    output logic signed [tsd_pkg::SPEED_W-1:0] fling_speed,
    output logic signed [tsd_pkg::SHIFT_W-1:0] drag_shift,
    output logic                             is_moving,
    output logic                             is_click,
    input  logic                             cfg_we,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tsd_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int XW = ((DW > MAX_W) ? DW : MAX_W) + 2;
    localparam int EW = (DW > SHIFT_W) ? DW : SHIFT_W;

    function automatic logic before_plus(input logic [STAMP_BITS-1:0] a,
                                         input logic [STAMP_BITS-1:0] b,
                                         input logic [STAMP_BITS-1:0] k);
        logic [STAMP_BITS-1:0] diff;
        begin
            diff = a - b;
            before_plus = (a < b) || (diff < k);
        end
    endfunction

    // configuration
    logic [MIN_W-1:0] min_x_reg, min_y_reg;
    logic [MAX_W-1:0] max_x_reg, max_y_reg;
    logic [WIN_W-1:0] win_reg;

    // gesture state
    logic signed [COORD_BITS-1:0] down_x_reg, down_y_reg;
    logic signed [COORD_BITS-1:0] last_x_reg, last_y_reg;
    logic signed [COORD_BITS-1:0] prior_x_reg, prior_y_reg;
    logic [STAMP_BITS-1:0]        last_t_reg, prior_t_reg;
    logic                         moving_reg, click_reg;

    // captured event
    logic [KIND_W-1:0]            kind_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic [STAMP_BITS-1:0]        t_reg;
    logic                         ax_reg;

    // delta stage
    logic [DW-1:0]        adx_reg, ady_reg;
    logic                 dxneg_reg, dyneg_reg;
    logic                 fast_reg, clickok_reg;
    logic signed [DW-1:0] d_reg;

    // excess stage
    logic             fling_reg, full_reg, drag_reg, click_set_reg, neg_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;

    // output register
    logic                      out_valid_reg;
    logic                      gv_reg, mv_reg, ck_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [SHIFT_W-1:0] shift_reg;

    state_t   state_reg, state_next;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic accept, start_div, commit;

    tsd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------- delta stage logic ----------------
    logic signed [DW-1:0]         dx, dy, d_c;
    logic [DW-1:0]                adx_c, ady_c;
    logic signed [COORD_BITS-1:0] cur_c, ref_c;
    logic                         fast_c, clickok_c;

    always_comb
    begin
        dx    = DW'(last_x_reg) - DW'(prior_x_reg);
        dy    = DW'(last_y_reg) - DW'(prior_y_reg);
        adx_c = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ady_c = dy[DW-1] ? DW'(-dy) : DW'(dy);
        cur_c = ax_reg ? x_reg : y_reg;
        if (moving_reg)
        begin
            ref_c = ax_reg ? last_x_reg : last_y_reg;
        end
        else
        begin
            ref_c = ax_reg ? down_x_reg : down_y_reg;
        end
        d_c       = DW'(cur_c) - DW'(ref_c);
        fast_c    = (kind_reg == KIND_UP)
                    && before_plus(t_reg, last_t_reg, STAMP_BITS'(FLING_GAP_MS))
                    && before_plus(last_t_reg, prior_t_reg, STAMP_BITS'(FLING_GAP_MS));
        clickok_c = before_plus(t_reg, last_t_reg, STAMP_BITS'(win_reg));
    end

    // ---------------- excess stage logic ----------------
    logic signed [XW-1:0] adx_w, ady_w, minx_w, miny_w, maxx_w, maxy_w;
    logic signed [XW-1:0] ex_x, ex_y, ex_yr, ex_c, span_c, cap_c;
    logic [DW-1:0]        dmag;
    logic                 adx_gt, x_ok, y_ok, fling_c, full_c, drag_c, mv_up;

    always_comb
    begin
        adx_w  = $signed(XW'(adx_reg));
        ady_w  = $signed(XW'(ady_reg));
        minx_w = $signed(XW'(min_x_reg));
        miny_w = $signed(XW'(min_y_reg));
        maxx_w = $signed(XW'(max_x_reg));
        maxy_w = $signed(XW'(max_y_reg));
        adx_gt = adx_w > ady_w;
        x_ok   = ax_reg && (adx_w > minx_w);
        y_ok   = !ax_reg && (ady_w > miny_w);
        fling_c = fast_reg && (adx_gt ? x_ok : y_ok);
        ex_x   = adx_w - minx_w;
        ex_y   = ady_w - miny_w - XW'(Y_OFFSET);
        // small vertical excess is remapped onto the low steps
        if (ex_y < XW'(REMAP_LOW))
        begin
            ex_yr = XW'(REMAP_LOW_V);
        end
        else if (ex_y <= XW'(REMAP_MID))
        begin
            ex_yr = XW'(REMAP_MID_V);
        end
        else if (ex_y <= XW'(REMAP_HIGH))
        begin
            ex_yr = XW'(REMAP_HIGH_V);
        end
        else
        begin
            ex_yr = ex_y;
        end
        ex_c   = adx_gt ? ex_x : ex_yr;
        span_c = adx_gt ? (maxx_w - minx_w) : (maxy_w - miny_w);
        full_c = span_c <= XW'(0);
        cap_c  = (ex_c > span_c) ? span_c : ex_c;
        dmag   = d_reg[DW-1] ? DW'(-d_reg) : DW'(d_reg);
        mv_up  = (kind_reg == KIND_MOVE) || (kind_reg == KIND_UP);
        drag_c = mv_up && !fling_c && (d_reg != '0)
                 && (moving_reg || (dmag >= DW'(DRAG_START)));
    end

    // ---------------- FSM ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA:  state_next = ST_EXCESS;
            ST_EXCESS: state_next = (fling_c && !full_c) ? ST_LAUNCH : ST_FIN;
            ST_LAUNCH: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        start_div = 1'b0;
        commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_stall  = 1'b0;
            ST_LAUNCH: start_div = 1'b1;
            ST_FIN:    commit    = !out_valid_reg || !out_stall;
            default:   in_stall  = 1'b1;
        endcase
    end

    assign accept = in_valid && !in_stall;

    assign div_req.start = start_div;
    assign div_req.num   = num_reg;
    assign div_req.den   = den_reg;

    // ---------------- result ----------------
    logic [Q_W-1:0]            mag_c;
    logic signed [SPEED_W-1:0] speed_c;
    logic signed [EW-1:0]      d_ext;
    logic                      mv_new, ck_new, kind_known;

    always_comb
    begin
        mag_c   = full_reg ? Q_W'(SPEED_FULL) : div_rsp.quo;
        speed_c = neg_reg ? -SPEED_W'(mag_c) : SPEED_W'(mag_c);
        d_ext   = EW'(d_reg);
        kind_known = (kind_reg == KIND_DOWN) || (kind_reg == KIND_MOVE)
                     || (kind_reg == KIND_UP);
        mv_new = moving_reg;
        ck_new = click_reg;
        if (kind_reg == KIND_DOWN)
        begin
            mv_new = 1'b0;
            ck_new = 1'b0;
        end
        if (click_set_reg)
        begin
            ck_new = 1'b1;
        end
        if (fling_reg)
        begin
            mv_new = 1'b1;
        end
        if (drag_reg)
        begin
            mv_new = 1'b1;
            ck_new = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            min_x_reg     <= FLING_MIN_RST;
            max_x_reg     <= FLING_MAX_RST;
            min_y_reg     <= FLING_MIN_RST;
            max_y_reg     <= FLING_MAX_RST;
            win_reg       <= CLICK_WINDOW_RST;
            down_x_reg    <= '0;
            down_y_reg    <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            prior_x_reg   <= '0;
            prior_y_reg   <= '0;
            last_t_reg    <= '0;
            prior_t_reg   <= '0;
            moving_reg    <= 1'b0;
            click_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FLING_MIN_X:  min_x_reg <= cfg_data[MIN_W-1:0];
                    CFG_FLING_MAX_X:  max_x_reg <= cfg_data[MAX_W-1:0];
                    CFG_FLING_MIN_Y:  min_y_reg <= cfg_data[MIN_W-1:0];
                    CFG_FLING_MAX_Y:  max_y_reg <= cfg_data[MAX_W-1:0];
                    CFG_CLICK_WINDOW: win_reg   <= cfg_data[WIN_W-1:0];
                    default:          ;
                endcase
            end
            if (commit)
            begin
                moving_reg <= mv_new;
                click_reg  <= ck_new;
                if (kind_reg == KIND_DOWN)
                begin
                    down_x_reg <= x_reg;
                    down_y_reg <= y_reg;
                end
                if (kind_known)
                begin
                    prior_x_reg <= last_x_reg;
                    prior_y_reg <= last_y_reg;
                    prior_t_reg <= last_t_reg;
                    last_x_reg  <= x_reg;
                    last_y_reg  <= y_reg;
                    last_t_reg  <= t_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= event_kind;
            x_reg    <= touch_x;
            y_reg    <= touch_y;
            t_reg    <= stamp_ms;
            ax_reg   <= axis_is_x;
        end
        if (state_reg == ST_DELTA)
        begin
            adx_reg     <= adx_c;
            ady_reg     <= ady_c;
            dxneg_reg   <= dx[DW-1];
            dyneg_reg   <= dy[DW-1];
            fast_reg    <= fast_c;
            clickok_reg <= clickok_c;
            d_reg       <= d_c;
        end
        if (state_reg == ST_EXCESS)
        begin
            fling_reg     <= fling_c;
            full_reg      <= full_c;
            drag_reg      <= drag_c;
            click_set_reg <= (kind_reg == KIND_UP) && !fling_c && !moving_reg && clickok_reg;
            neg_reg       <= adx_gt ? dxneg_reg : dyneg_reg;
            num_reg       <= NUM_W'(cap_c[MAG_W-1:0]) * NUM_W'(SPEED_FULL);
            den_reg       <= span_c[DEN_W-1:0];
        end
        if (commit)
        begin
            gv_reg    <= fling_reg || drag_reg;
            speed_reg <= fling_reg ? speed_c : '0;
            shift_reg <= drag_reg ? d_ext[SHIFT_W-1:0] : '0;
            mv_reg    <= mv_new;
            ck_reg    <= ck_new;
        end
    end

    assign out_valid     = out_valid_reg;
    assign gesture_valid = gv_reg;
    assign fling_speed   = speed_reg;
    assign drag_shift    = shift_reg;
    assign is_moving     = mv_reg;
    assign is_click      = ck_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DELTA))
        else $error("accepted transfer did not start work");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("finished result not presented");

    a_idle_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !gv_reg) |-> (speed_reg == '0 && shift_reg == '0))
        else $error("payload nonzero with no gesture");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(speed_reg != '0 && shift_reg != '0))
        else $error("fling and drag reported together");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |-> (div_rsp.busy || div_rsp.done))
        else $error("waiting on an idle divider");

endmodule

[test/tb_touch_swipe_detector_top.sv]
module tb_touch_swipe_detector_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tsd_pkg::*;

    typedef struct packed {
        logic                 gv;
        logic [SPEED_W-1:0]   speed;
        logic [SHIFT_W-1:0]   shift;
        logic                 moving;
        logic                 click;
    } gesture_t;

    // Tracks the detector state, turns each accepted touch event into the gesture it should
    // report and matches reported gestures against them in order.
    class gesture_ledger;
        longint          min_x, max_x, min_y, max_y, click_ms;
        longint          down_x, down_y, last_x, last_y, prior_x, prior_y;
        longint unsigned last_t, prior_t;
        bit              moving, click;
        gesture_t        due[$];
        int unsigned     seen, bad, flings, drags, clicks, ignored;

        function new();
            min_x    = FLING_MIN_RST;
            max_x    = FLING_MAX_RST;
            min_y    = FLING_MIN_RST;
            max_y    = FLING_MAX_RST;
            click_ms = CLICK_WINDOW_RST;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FLING_MIN_X:  min_x = val[MIN_W-1:0];
                CFG_FLING_MAX_X:  max_x = val[MAX_W-1:0];
                CFG_FLING_MIN_Y:  min_y = val[MIN_W-1:0];
                CFG_FLING_MAX_Y:  max_y = val[MAX_W-1:0];
                CFG_CLICK_WINDOW: click_ms = val[WIN_W-1:0];
                default: ;
            endcase
        endfunction

        // a < b + k with no wrap of the stamp
        function bit soon(longint unsigned a, longint unsigned b, longint unsigned k);
            return (a < b) || (a - b < k);
        endfunction

        function longint scale(longint excess, longint span);
            longint e;
            e = excess;
            if (span <= 0)
                return SPEED_FULL;
            if (e > span)
                e = span;
            return e * SPEED_FULL / span;
        endfunction

        function void log_event(logic [KIND_W-1:0] kind, logic signed [15:0] x,
                                logic signed [15:0] y, logic [31:0] t, logic ax);
            longint          sx, sy, dx, dy, adx, ady, e, d, speed, shift;
            longint unsigned st;
            bit              fling, gv;
            gesture_t        r;
            sx = x;
            sy = y;
            st = t;
            fling = 1'b0;
            gv = 1'b0;
            speed = 0;
            shift = 0;
            if (kind == KIND_DOWN)
            begin
                down_x = sx;
                down_y = sy;
                moving = 1'b0;
                click = 1'b0;
            end
            else if (kind == KIND_MOVE || kind == KIND_UP)
            begin
                if (kind == KIND_UP)
                begin
                    if (soon(st, last_t, FLING_GAP_MS) &&
                        soon(last_t, prior_t, FLING_GAP_MS))
                    begin
                        dx = last_x - prior_x;
                        dy = last_y - prior_y;
                        adx = dx < 0 ? -dx : dx;
                        ady = dy < 0 ? -dy : dy;
                        if (adx > ady)
                        begin
                            if (ax && adx > min_x)
                            begin
                                speed = scale(adx - min_x, max_x - min_x);
                                if (dx < 0)
                                    speed = -speed;
                                fling = 1'b1;
                            end
                        end
                        else if (!ax && ady > min_y)
                        begin
                            // small y excess is folded into three fixed steps
                            e = ady - min_y - Y_OFFSET;
                            if (e < REMAP_LOW)
                                e = REMAP_LOW_V;
                            else if (e <= REMAP_MID)
                                e = REMAP_MID_V;
                            else if (e <= REMAP_HIGH)
                                e = REMAP_HIGH_V;
                            speed = scale(e, max_y - min_y);
                            if (dy < 0)
                                speed = -speed;
                            fling = 1'b1;
                        end
                    end
                    if (fling)
                    begin
                        moving = 1'b1;
                        gv = 1'b1;
                        flings++;
                    end
                    else
                    begin
                        speed = 0;
                        if (!moving && soon(st, last_t, click_ms))
                        begin
                            click = 1'b1;
                            clicks++;
                        end
                    end
                end
                if (!fling)
                begin
                    if (moving)
                        d = ax ? sx - last_x : sy - last_y;
                    else
                        d = ax ? sx - down_x : sy - down_y;
                    if (d != 0 && (moving || d >= DRAG_START || -d >= DRAG_START))
                    begin
                        moving = 1'b1;
                        click = 1'b0;
                        gv = 1'b1;
                        shift = d;
                        drags++;
                    end
                end
            end
            else
                ignored++;

            if (kind <= KIND_UP)
            begin
                prior_x = last_x;
                prior_y = last_y;
                prior_t = last_t;
                last_x = sx;
                last_y = sy;
                last_t = st;
            end

            r.gv = gv;
            r.speed = gv ? speed[SPEED_W-1:0] : '0;
            r.shift = gv ? shift[SHIFT_W-1:0] : '0;
            r.moving = moving;
            r.click = click;
            due.push_back(r);
        endfunction

        function void match_gesture(gesture_t got);
            gesture_t want;
            if (due.size() == 0)
            begin
                if (bad < 10)
                    $display("unexpected result: gv=%0b speed=%0d shift=%0d moving=%0b click=%0b",
                             got.gv, $signed(got.speed), $signed(got.shift), got.moving,
                             got.click);
                bad++;
                return;
            end
            want = due.pop_front();
            seen++;
            if (got.gv !== want.gv || got.speed !== want.speed || got.shift !== want.shift ||
                got.moving !== want.moving || got.click !== want.click)
            begin
                if (bad < 10)
                begin
                    $display("result %0d: want gv=%0b speed=%0d shift=%0d moving=%0b click=%0b",
                             seen, want.gv, $signed(want.speed), $signed(want.shift),
                             want.moving, want.click);
                    $display("    got gv=%0b speed=%0d shift=%0d moving=%0b click=%0b",
                             got.gv, $signed(got.speed), $signed(got.shift),
                             got.moving, got.click);
                end
                bad++;
            end
        endfunction
    endclass

    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [KIND_W-1:0]        event_kind = KIND_DOWN;
    logic signed [15:0]       touch_x = '0;
    logic signed [15:0]       touch_y = '0;
    logic [31:0]              stamp_ms = '0;
    logic                     axis_is_x = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     gesture_valid;
    logic signed [SPEED_W-1:0] fling_speed;
    logic signed [SHIFT_W-1:0] drag_shift;
    logic                     is_moving;
    logic                     is_click;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_FLING_MIN_X;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    gesture_ledger            ledger;
    bit                       steady;
    int unsigned              sent;
    int unsigned              settings;
    logic signed [15:0]       pos_x, pos_y;
    logic [31:0]              clock_ms;
    logic                     axis;

    touch_swipe_detector_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .event_kind   (event_kind),
        .touch_x      (touch_x),
        .touch_y      (touch_y),
        .stamp_ms     (stamp_ms),
        .axis_is_x    (axis_is_x),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .gesture_valid(gesture_valid),
        .fling_speed  (fling_speed),
        .drag_shift   (drag_shift),
        .is_moving    (is_moving),
        .is_click     (is_click),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin : result_side
        gesture_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{gesture_valid, fling_speed, drag_shift, is_moving, is_click};
            ledger.match_gesture(got);
        end
        out_stall <= rst_n && !steady && ($urandom_range(0, 99) < 32);
    end

    task automatic send_event(logic [KIND_W-1:0] kind, logic signed [15:0] x,
                              logic signed [15:0] y, logic [31:0] t, logic ax);
        int gap;
        gap = 0;
        while (!steady && gap < 40 && $urandom_range(0, 99) < 32)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        event_kind <= kind;
        touch_x    <= x;
        touch_y    <= y;
        stamp_ms   <= t;
        axis_is_x  <= ax;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // transfer done at this edge
        ledger.log_event(kind, x, y, t, ax);
        if (kind != KIND_IGNORED)
            sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.due.size() != 0)
            @(posedge clk);
    endtask

    // idle before register writes
    task automatic settle();
        drain();
        repeat (20) @(posedge clk);
    endtask

    task automatic load_regs(logic [CFG_DATA_W-1:0] mnx, mxx, mny, mxy, win);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        idx = '{CFG_FLING_MIN_X, CFG_FLING_MAX_X, CFG_FLING_MIN_Y, CFG_FLING_MAX_Y,
                CFG_CLICK_WINDOW};
        val = '{mnx, mxx, mny, mxy, win};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            ledger.set_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic int pick_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return int'($urandom_range(0, 80)) - 40;
        if (r < 90)
            return int'($urandom_range(0, 800)) - 400;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic void advance();
        if ($urandom_range(0, 4) != 0)
            clock_ms += $urandom_range(0, 70);
        else
            clock_ms += $urandom_range(0, 700);
        pos_x += 16'(pick_delta());
        pos_y += 16'(pick_delta());
        if ($urandom_range(0, 9) == 0)
            axis = ~axis;
    endfunction

    // down, a few moves, up; sometimes without the down, sometimes with stray events
    task automatic gesture();
        int moves;
        if ($urandom_range(0, 19) == 0)
            clock_ms = $urandom;
        else
            clock_ms += $urandom_range(61, 3000);
        if ($urandom_range(0, 3) == 0)
        begin
            pos_x = 16'($urandom);
            pos_y = 16'($urandom);
        end
        else
        begin
            pos_x = 16'(int'($urandom_range(0, 2000)) - 1000);
            pos_y = 16'(int'($urandom_range(0, 2000)) - 1000);
        end
        axis = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) != 0)
            send_event(KIND_DOWN, pos_x, pos_y, clock_ms, axis);
        moves = $urandom_range(0, 5);
        repeat (moves)
        begin
            advance();
            send_event(KIND_MOVE, pos_x, pos_y, clock_ms, axis);
        end
        advance();
        send_event(KIND_UP, pos_x, pos_y, clock_ms, axis);
        if ($urandom_range(0, 9) == 0)
        begin
            advance();
            send_event(KIND_UP, pos_x, pos_y, clock_ms, axis);
        end
        if ($urandom_range(0, 11) == 0)
            send_event(KIND_W'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), $urandom,
                       1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int unsigned start_count;
        int          n;
        logic [CFG_DATA_W-1:0] rx, ry;
        ledger = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // drag start, full-speed and negative x flings
        send_event(KIND_DOWN, 0, 0, 1000, 1'b1);
        send_event(KIND_MOVE, 10, 0, 1010, 1'b1);
        send_event(KIND_MOVE, 240, 0, 1020, 1'b1);
        send_event(KIND_UP, 240, 0, 1030, 1'b1);
        send_event(KIND_DOWN, 500, 500, 2000, 1'b1);
        send_event(KIND_MOVE, 470, 500, 2010, 1'b1);
        send_event(KIND_MOVE, 400, 500, 2020, 1'b1);
        send_event(KIND_UP, 400, 500, 2030, 1'b1);
        // tap
        send_event(KIND_DOWN, 7, 7, 3000, 1'b1);
        send_event(KIND_UP, 10, 7, 3100, 1'b1);
        // stamps near the top, then going back below the last one
        send_event(KIND_DOWN, 0, 0, 32'hFFFF_FFF0, 1'b1);
        send_event(KIND_MOVE, 60, 0, 32'hFFFF_FFF8, 1'b1);
        send_event(KIND_UP, 60, 0, 5, 1'b1);
        // coordinate extremes, widest shifts, tied deltas
        send_event(KIND_DOWN, -32768, 32767, 0, 1'b0);
        send_event(KIND_MOVE, 32767, -32768, 10, 1'b0);
        send_event(KIND_MOVE, -32768, 32767, 20, 1'b1);
        send_event(KIND_UP, -32768, 32767, 30, 1'b1);
        send_event(KIND_IGNORED, 1234, -1234, 40, 1'b1);

        // narrow y span so the three remap steps give distinct speeds
        settle();
        load_regs(FLING_MIN_RST, FLING_MAX_RST, FLING_MIN_RST, 23, CLICK_WINDOW_RST);
        send_event(KIND_DOWN, 0, 0, 5000, 1'b0);
        send_event(KIND_MOVE, 0, 21, 5010, 1'b0);
        send_event(KIND_UP, 0, 21, 5020, 1'b0);
        send_event(KIND_MOVE, 0, 47, 5030, 1'b0);
        send_event(KIND_UP, 0, 47, 5040, 1'b0);
        send_event(KIND_MOVE, 0, 79, 5050, 1'b0);
        send_event(KIND_UP, 0, 79, 5060, 1'b0);

        for (int phase = 0; phase < 7; phase++)
        begin
            settle();
            case (phase)
                0: load_regs(FLING_MIN_RST, FLING_MAX_RST, FLING_MIN_RST, FLING_MAX_RST,
                             CLICK_WINDOW_RST);
                1: load_regs(0, 4096, 0, 4096, 16'hFFFF);
                2: load_regs(4095, 1, 4095, 1, 0);
                3: load_regs(30, 30, 12, 12, 100);
                default:
                begin
                    rx = CFG_DATA_W'($urandom_range(0, 60));
                    ry = CFG_DATA_W'($urandom_range(0, 60));
                    load_regs(rx, rx + CFG_DATA_W'($urandom_range(1, 400)), ry,
                              ry + CFG_DATA_W'($urandom_range(1, 400)),
                              CFG_DATA_W'($urandom_range(0, 1000)));
                end
            endcase
            steady = (phase == 2);
            start_count = sent;
            n = 0;
            while (sent - start_count < 72)
            begin
                gesture();
                n++;
                if (n == 3 || $urandom_range(0, 39) == 0)
                    drain();
            end
        end

        steady = 1'b0;
        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d touch events (%0d ignored kinds) under %0d register settings",
                 sent, ledger.ignored, settings);
        $display("saw %0d flings, %0d drags, %0d clicks; %0d results checked",
                 ledger.flings, ledger.drags, ledger.clicks, ledger.seen);
        if (ledger.bad == 0 && ledger.due.size() == 0)
            $display("tb_touch_swipe_detector_top OK");
        else
            $display("tb_touch_swipe_detector_top NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", ledger.due.size());
        $display("tb_touch_swipe_detector_top NOT OK");
        $finish;
    end
endmodule
